FILE: rtl/stabilizer_crop_offset_defines.svh
// ----------------------------------------------------------------------------
// Stabilizer crop offset assertion macros
// Shared concurrent assertion forms used at the top level.
// ----------------------------------------------------------------------------
`ifndef STABILIZER_CROP_OFFSET_DEFINES_SVH
`define STABILIZER_CROP_OFFSET_DEFINES_SVH

// Check a property in the same cycle as its trigger.
`define SCO_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("stabilizer_crop_offset: assertion failed");

// Check a property in the cycle after its trigger.
`define SCO_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("stabilizer_crop_offset: assertion failed");

`endif

FILE: rtl/sco_pkg.sv
// ----------------------------------------------------------------------------
// Stabilizer crop offset package
// Widths, codes, types and helper functions shared by the block.
// ----------------------------------------------------------------------------
package sco_pkg;

    localparam int ANG_W      = 17;
    localparam int GAIN_W     = 17;
    localparam int FOV_W      = 16;
    localparam int SIZE_W     = 14;
    localparam int RATIO_W    = 15;
    localparam int SCALE_W    = 16;
    localparam int SHIFT_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_IMAGE_DIM    = 8192;
    localparam int TAN_ITER_DEFAULT = 16;

    localparam int HALF_TURN    = 46080;
    localparam int FULL_TURN    = 92160;
    localparam int QUARTER_TURN = 23040;
    localparam int FOV_MAX      = 45823;
    localparam int GAIN_ONE     = 65536;
    localparam int SCALE_ONE    = 4096;
    localparam int ROUND_HALF   = 32768;

    localparam int XY_W        = 24;
    localparam int Z_W         = 30;
    localparam int ATAN_W      = 27;
    localparam int ATAN_IDX_W  = 5;
    localparam int CORDIC_ONE  = 1 << 20;
    localparam int LIM_W       = SIZE_W + RATIO_W - 12;

    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 17'd6554;
    localparam logic [FOV_W-1:0]   HFOV_RESET   = 16'd15360;
    localparam logic [FOV_W-1:0]   VFOV_RESET   = 16'd11520;
    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 14'd1920;
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 14'd1080;
    localparam logic [RATIO_W-1:0] RATIO_RESET  = 15'd6554;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd5120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN   = 3'd0,
        CFG_HFOV   = 3'd1,
        CFG_VFOV   = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4,
        CFG_RATIO  = 3'd5,
        CFG_SCALE  = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_FOLLOW,
        LN_ERROR,
        LN_ROTATE,
        LN_PRODUCT,
        LN_MAGNITUDE,
        LN_DIVIDE,
        LN_DONE
    } lane_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  alpha;
        logic [FOV_W-1:0]   fov;
        logic [SIZE_W-1:0]  size;
        logic [RATIO_W-1:0] ratio;
        logic [SCALE_W-1:0] scale;
    } lane_cfg_t;

    typedef struct packed {
        logic start;
        logic capture;
    } lane_ctl_t;

    function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W:0] v);
        logic signed [ANG_W:0] r;
        r = v;
        if (v >= (ANG_W+1)'(HALF_TURN))
        begin
            r = v - (ANG_W+1)'(FULL_TURN);
        end
        else if (v < -(ANG_W+1)'(HALF_TURN))
        begin
            r = v + (ANG_W+1)'(FULL_TURN);
        end
        return r[ANG_W-1:0];
    endfunction

    function automatic logic [ATAN_W-1:0] atan_deg20(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] r;
        case (idx)
            5'd0:    r = 27'd47185920;
            5'd1:    r = 27'd27855475;
            5'd2:    r = 27'd14718068;
            5'd3:    r = 27'd7471121;
            5'd4:    r = 27'd3750058;
            5'd5:    r = 27'd1876857;
            5'd6:    r = 27'd938658;
            5'd7:    r = 27'd469357;
            5'd8:    r = 27'd234682;
            5'd9:    r = 27'd117342;
            5'd10:   r = 27'd58671;
            5'd11:   r = 27'd29335;
            5'd12:   r = 27'd14668;
            5'd13:   r = 27'd7334;
            5'd14:   r = 27'd3667;
            5'd15:   r = 27'd1833;
            5'd16:   r = 27'd917;
            5'd17:   r = 27'd458;
            5'd18:   r = 27'd229;
            5'd19:   r = 27'd115;
            5'd20:   r = 27'd57;
            5'd21:   r = 27'd29;
            5'd22:   r = 27'd14;
            5'd23:   r = 27'd7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/sco_if.sv
// ----------------------------------------------------------------------------
// Stabilizer crop offset channels
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sco_sample_if;
    logic                     valid;
    logic                     ready;
    logic signed [16:0]       yaw_angle;
    logic signed [16:0]       pitch_angle;
    logic                     resync;

    modport source (output valid, yaw_angle, pitch_angle, resync, input ready);
    modport sink (input valid, yaw_angle, pitch_angle, resync, output ready);
endinterface

interface sco_result_if;
    logic                     valid;
    logic                     ready;
    logic signed [17:0]       dx_shift;
    logic signed [17:0]       dy_shift;
    logic [15:0]              scale_out;
    logic                     status;

    modport source (output valid, dx_shift, dy_shift, scale_out, status, input ready);
    modport sink (input valid, dx_shift, dy_shift, scale_out, status, output ready);
endinterface

interface sco_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               index;
    logic [16:0]              data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/stabilizer_crop_offset.sv
// A captured sample needs no lane work; for a tracked sample the delay is set by the
// CORDIC loop, the 17-step limit divider and the 17-step shift divider, the last one
// skipped when the shift is saturated or zero. The result waits while the output
// register is full and not taken. A new sample is taken only when none is in flight,
// from the cycle after the result is loaded into the output register.
// Reset (async, active low) restores register defaults, zeroes angles, clears primed.
// ----------------------------------------------------------------------------
// Stabilizer crop offset
// Smooths yaw and pitch in two lanes and merges the crop shifts.
// ----------------------------------------------------------------------------
`include "stabilizer_crop_offset_defines.svh"

module stabilizer_crop_offset #(
    parameter int TAN_ITERATIONS = sco_pkg::TAN_ITER_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    sco_sample_if.sink  sample,
    sco_result_if.source result,
    sco_cfg_if.sink     cfg
);
    import sco_pkg::*;

    logic [GAIN_W-1:0]  gain_reg;
    logic [FOV_W-1:0]   hfov_reg;
    logic [FOV_W-1:0]   vfov_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic               busy_reg;
    logic               cap_reg;
    logic               primed_reg;
    logic               out_valid_reg;
    logic signed [SHIFT_W-1:0] dx_reg;
    logic signed [SHIFT_W-1:0] dy_reg;
    logic [SCALE_W-1:0] scale_out_reg;
    logic               status_reg;

    logic               in_take;
    logic               out_load;
    logic               capture;
    logic [GAIN_W-1:0]  alpha;
    logic [SCALE_W-1:0] scale_eff;
    logic [SIZE_W-1:0]  width_eff;
    logic [SIZE_W-1:0]  height_eff;
    logic [FOV_W-1:0]   hfov_eff;
    logic [FOV_W-1:0]   vfov_eff;
    lane_cfg_t          cfg_x, cfg_y;
    lane_ctl_t          ctl;
    logic signed [ANG_W-1:0]   yaw_w, pitch_w;
    logic               done_x, done_y;
    logic signed [SHIFT_W-1:0] shift_x, shift_y;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            hfov_reg   <= HFOV_RESET;
            vfov_reg   <= VFOV_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            ratio_reg  <= RATIO_RESET;
            scale_reg  <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_GAIN:   gain_reg   <= cfg.data[GAIN_W-1:0];
                CFG_HFOV:   hfov_reg   <= cfg.data[FOV_W-1:0];
                CFG_VFOV:   vfov_reg   <= cfg.data[FOV_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg.data[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg.data[SIZE_W-1:0];
                CFG_RATIO:  ratio_reg  <= cfg.data[RATIO_W-1:0];
                CFG_SCALE:  scale_reg  <= cfg.data[SCALE_W-1:0];
                default:    gain_reg   <= gain_reg;
            endcase
        end
    end

    assign alpha      = (gain_reg > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : gain_reg;
    assign scale_eff  = (scale_reg < SCALE_W'(SCALE_ONE)) ? SCALE_W'(SCALE_ONE) : scale_reg;
    assign width_eff  = (width_reg > SIZE_W'(MAX_IMAGE_DIM)) ? SIZE_W'(MAX_IMAGE_DIM)
                                                             : width_reg;
    assign height_eff = (height_reg > SIZE_W'(MAX_IMAGE_DIM)) ? SIZE_W'(MAX_IMAGE_DIM)
                                                              : height_reg;
    assign hfov_eff   = (hfov_reg == '0) ? FOV_W'(1) :
                        (hfov_reg > FOV_W'(FOV_MAX)) ? FOV_W'(FOV_MAX) : hfov_reg;
    assign vfov_eff   = (vfov_reg == '0) ? FOV_W'(1) :
                        (vfov_reg > FOV_W'(FOV_MAX)) ? FOV_W'(FOV_MAX) : vfov_reg;

    assign cfg_x = '{alpha: alpha, fov: hfov_eff, size: width_eff, ratio: ratio_reg,
                     scale: scale_eff};
    assign cfg_y = '{alpha: alpha, fov: vfov_eff, size: height_eff, ratio: ratio_reg,
                     scale: scale_eff};

    assign yaw_w   = wrap_angle($signed({sample.yaw_angle[ANG_W-1], sample.yaw_angle}));
    assign pitch_w = wrap_angle($signed({sample.pitch_angle[ANG_W-1], sample.pitch_angle}));

    assign sample.ready = !busy_reg;
    assign in_take      = sample.valid && !busy_reg;
    assign capture      = !primed_reg || sample.resync;
    assign ctl          = '{start: in_take, capture: capture};

    sco_lane #(.TAN_ITERATIONS(TAN_ITERATIONS)) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (yaw_w),
        .cfg    (cfg_x),
        .done   (done_x),
        .shift  (shift_x)
    );

    sco_lane #(.TAN_ITERATIONS(TAN_ITERATIONS)) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (pitch_w),
        .cfg    (cfg_y),
        .done   (done_y),
        .shift  (shift_y)
    );

    assign out_load = busy_reg && done_x && done_y && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cap_reg       <= 1'b0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                busy_reg   <= 1'b1;
                cap_reg    <= capture;
                primed_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dx_reg        <= shift_x;
            dy_reg        <= shift_y;
            scale_out_reg <= scale_reg;
            status_reg    <= cap_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.dx_shift  = dx_reg;
    assign result.dy_shift  = dy_reg;
    assign result.scale_out = scale_out_reg;
    assign result.status    = status_reg;

    `SCO_ASSERT_NEXT(a_accept_busy, clk, rst_n, sample.valid && sample.ready, busy_reg)
    `SCO_ASSERT_IMPL(a_capture_zero, clk, rst_n, result.valid && result.status, result.dx_shift == 0 && result.dy_shift == 0)
    `SCO_ASSERT_IMPL(a_dx_range, clk, rst_n, result.valid, result.dx_shift >= -18'sd65536 && result.dx_shift <= 18'sd65536)
    `SCO_ASSERT_IMPL(a_dy_range, clk, rst_n, result.valid, result.dy_shift >= -18'sd65536 && result.dy_shift <= 18'sd65536)

endmodule

FILE: rtl/sco_div.sv
// ----------------------------------------------------------------------------
// Stabilizer crop offset divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sco_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 16,
    parameter int QUO_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);
    localparam int CNT_W = $clog2(QUO_W);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] low_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};
    assign busy  = busy_reg;
    assign quo   = low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= cnt_reg != CNT_W'(QUO_W - 1);
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(num >> QUO_W);
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], ge};
        end
    end

endmodule

FILE: rtl/sco_cordic.sv
// ----------------------------------------------------------------------------
// Stabilizer crop offset CORDIC
// Iterative rotation giving sine and cosine of an angle in 2^-20 degree.
// ----------------------------------------------------------------------------
module sco_cordic #(
    parameter int ITER = sco_pkg::TAN_ITER_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [sco_pkg::Z_W-1:0]   angle,
    output logic                             busy,
    output logic signed [sco_pkg::XY_W-1:0]  sin_out,
    output logic signed [sco_pkg::XY_W-1:0]  cos_out
);
    import sco_pkg::*;

    localparam int CNT_W = $clog2(ITER);

    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic signed [XY_W-1:0]  x_sh;
    logic signed [XY_W-1:0]  y_sh;
    logic signed [Z_W-1:0]   atan_z;
    logic                    pos;

    assign x_sh    = x_reg >>> cnt_reg;
    assign y_sh    = y_reg >>> cnt_reg;
    assign atan_z  = signed'(Z_W'(atan_deg20(ATAN_IDX_W'(cnt_reg))));
    assign pos     = !z_reg[Z_W-1];
    assign busy    = busy_reg;
    assign sin_out = y_reg;
    assign cos_out = x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= cnt_reg != CNT_W'(ITER - 1);
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= XY_W'(CORDIC_ONE);
            y_reg <= '0;
            z_reg <= angle;
        end
        else if (busy_reg)
        begin
            x_reg <= pos ? x_reg - y_sh : x_reg + y_sh;
            y_reg <= pos ? y_reg + x_sh : y_reg - x_sh;
            z_reg <= pos ? z_reg - atan_z : z_reg + atan_z;
        end
    end

endmodule

FILE: rtl/sco_lane.sv
// ----------------------------------------------------------------------------
// Stabilizer crop offset lane
// Smooths one axis and turns the remaining error into a saturated shift.
// ----------------------------------------------------------------------------
module sco_lane #(
    parameter int TAN_ITERATIONS = sco_pkg::TAN_ITER_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sco_pkg::lane_ctl_t                 ctl,
    input  logic signed [sco_pkg::ANG_W-1:0]   sample,
    input  sco_pkg::lane_cfg_t                 cfg,
    output logic                               done,
    output logic signed [sco_pkg::SHIFT_W-1:0] shift
);
    import sco_pkg::*;

    localparam int PROD_W = ANG_W + GAIN_W + 1;
    localparam int PT_W   = 2 * XY_W;
    localparam int DEN_W  = PT_W - 1;
    localparam int MAG_W  = PT_W + SIZE_W + 3;
    localparam int NUM_W  = MAG_W + 1;
    localparam int L2_W   = SIZE_W + SCALE_W + 3;

    lane_state_t state_reg, state_next;

    logic signed [ANG_W-1:0]   smooth_reg;
    logic signed [ANG_W-1:0]   sample_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PT_W-1:0]    t_reg;
    logic signed [PT_W-1:0]    den_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic signed [SHIFT_W-1:0] shift_reg;

    logic signed [ANG_W-1:0]   err_in;
    logic signed [GAIN_W:0]    alpha_s;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  step_full;
    logic signed [ANG_W:0]     step;
    logic signed [ANG_W-1:0]   smooth_new;
    logic signed [ANG_W-1:0]   err_out;
    logic signed [ANG_W-1:0]   err_fold;
    logic signed [Z_W-1:0]     z_err;
    logic signed [Z_W-1:0]     z_fov;
    logic signed [XY_W-1:0]    sin_e, cos_e, sin_h, cos_h;
    logic                      err_busy, fov_busy;
    logic signed [PT_W-1:0]    t_next;
    logic signed [PT_W-1:0]    den_next;
    logic [PT_W-1:0]           abs_t;
    logic [PT_W+SIZE_W-1:0]    t_size;
    logic [DEN_W-1:0]          den_u;
    logic                      den_pos;
    logic [NUM_W-1:0]          num_q;
    logic                      sat_q;
    logic [SIZE_W+RATIO_W-1:0] ratio_prod;
    logic [LIM_W-1:0]          l1;
    logic [SCALE_W-1:0]        sc_excess;
    logic [SIZE_W+SCALE_W-1:0] scale_prod;
    logic [L2_W-1:0]           l2_num;
    logic [LIM_W-1:0]          l2;
    logic [LIM_W-1:0]          lim;
    logic [LIM_W-1:0]          q_quo;
    logic [LIM_W-1:0]          q_sel;
    logic signed [SHIFT_W-1:0] shift_val;
    logic                      lim_busy, q_busy;
    logic                      idle;
    logic                      cordic_start, lim_start, q_start;

    assign idle       = state_reg == LN_IDLE || state_reg == LN_DONE;
    assign err_in     = wrap_angle($signed({sample[ANG_W-1], sample})
                                   - $signed({smooth_reg[ANG_W-1], smooth_reg}));
    assign alpha_s    = $signed({1'b0, cfg.alpha});
    assign prod_next  = alpha_s * err_in;
    assign step_full  = (prod_reg + PROD_W'(ROUND_HALF)) >>> 16;
    assign step       = $signed(step_full[ANG_W:0]);
    assign smooth_new = wrap_angle($signed({smooth_reg[ANG_W-1], smooth_reg}) + step);
    assign err_out    = wrap_angle($signed({smooth_reg[ANG_W-1], smooth_reg})
                                   - $signed({sample_reg[ANG_W-1], sample_reg}));

    always_comb
    begin
        err_fold = err_out;
        if (err_out > ANG_W'(QUARTER_TURN))
        begin
            err_fold = err_out - ANG_W'(HALF_TURN);
        end
        else if (err_out < -ANG_W'(QUARTER_TURN))
        begin
            err_fold = err_out + ANG_W'(HALF_TURN);
        end
    end

    assign z_err = Z_W'($signed({err_fold, 12'b0}));
    assign z_fov = signed'(Z_W'({cfg.fov, 11'b0}));

    sco_cordic #(.ITER(TAN_ITERATIONS)) u_cordic_err (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (z_err),
        .busy    (err_busy),
        .sin_out (sin_e),
        .cos_out (cos_e)
    );

    sco_cordic #(.ITER(TAN_ITERATIONS)) u_cordic_fov (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (z_fov),
        .busy    (fov_busy),
        .sin_out (sin_h),
        .cos_out (cos_h)
    );

    assign t_next   = sin_e * cos_h;
    assign den_next = cos_e * sin_h;
    assign abs_t    = t_reg[PT_W-1] ? $unsigned(-t_reg) : $unsigned(t_reg);
    assign t_size   = abs_t * cfg.size;
    assign den_u    = den_reg[DEN_W-1:0];
    assign den_pos  = !den_reg[PT_W-1] && (den_reg != '0);
    assign num_q    = NUM_W'(mag_reg) + NUM_W'(den_u >> 1);
    assign sat_q    = num_q >= NUM_W'({den_u, {LIM_W{1'b0}}});

    assign ratio_prod = cfg.size * cfg.ratio;
    assign l1         = ratio_prod[SIZE_W+RATIO_W-1:12];
    assign sc_excess  = cfg.scale - SCALE_W'(SCALE_ONE);
    assign scale_prod = cfg.size * sc_excess;
    assign l2_num     = {scale_prod, 3'b000};

    sco_div #(.NUM_W(L2_W), .DEN_W(SCALE_W), .QUO_W(LIM_W)) u_div_lim (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lim_start),
        .num   (l2_num),
        .den   (cfg.scale),
        .busy  (lim_busy),
        .quo   (l2)
    );

    sco_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(LIM_W)) u_div_shift (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_start),
        .num   (num_q),
        .den   (den_u),
        .busy  (q_busy),
        .quo   (q_quo)
    );

    assign lim       = (l1 < l2) ? l1 : l2;
    assign q_sel     = (state_reg == LN_DIVIDE && q_quo < lim) ? q_quo : lim;
    assign shift_val = (t_reg == '0) ? '0 :
                       t_reg[PT_W-1] ? $signed({1'b0, q_sel}) : -$signed({1'b0, q_sel});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE, LN_DONE:
            begin
                if (ctl.start)
                begin
                    state_next = ctl.capture ? LN_DONE : LN_FOLLOW;
                end
            end
            LN_FOLLOW:
            begin
                state_next = LN_ERROR;
            end
            LN_ERROR:
            begin
                state_next = LN_ROTATE;
            end
            LN_ROTATE:
            begin
                if (!err_busy && !fov_busy)
                begin
                    state_next = LN_PRODUCT;
                end
            end
            LN_PRODUCT:
            begin
                state_next = LN_MAGNITUDE;
            end
            LN_MAGNITUDE:
            begin
                if (!lim_busy)
                begin
                    state_next = (t_reg == '0 || !den_pos || sat_q) ? LN_DONE : LN_DIVIDE;
                end
            end
            LN_DIVIDE:
            begin
                if (!q_busy)
                begin
                    state_next = LN_DONE;
                end
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cordic_start = 1'b0;
        lim_start    = 1'b0;
        q_start      = 1'b0;
        case (state_reg)
            LN_IDLE, LN_DONE:
            begin
                lim_start = ctl.start && !ctl.capture;
            end
            LN_ERROR:
            begin
                cordic_start = 1'b1;
            end
            LN_MAGNITUDE:
            begin
                q_start = !lim_busy && t_reg != '0 && den_pos && !sat_q;
            end
            default:
            begin
                cordic_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= LN_IDLE;
            smooth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (idle && ctl.start && ctl.capture)
            begin
                smooth_reg <= sample;
            end
            else if (state_reg == LN_FOLLOW)
            begin
                smooth_reg <= smooth_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LN_IDLE, LN_DONE:
            begin
                if (ctl.start)
                begin
                    sample_reg <= sample;
                    prod_reg   <= prod_next;
                    if (ctl.capture)
                    begin
                        shift_reg <= '0;
                    end
                end
            end
            LN_ROTATE:
            begin
                t_reg   <= t_next;
                den_reg <= den_next;
            end
            LN_PRODUCT:
            begin
                mag_reg <= {t_size, 3'b000};
            end
            LN_MAGNITUDE:
            begin
                if (!lim_busy)
                begin
                    shift_reg <= shift_val;
                end
            end
            LN_DIVIDE:
            begin
                shift_reg <= shift_val;
            end
            default:
            begin
                shift_reg <= shift_reg;
            end
        endcase
    end

    assign done  = state_reg == LN_DONE;
    assign shift = shift_reg;

endmodule
